FILE: rtl/core/e2q_pkg.sv
`default_nettype none

package e2q_pkg;

  localparam int ANGLE_WIDTH = 16;
  localparam int OUT_WIDTH   = 16;

  localparam int CORDIC_ITERS  = 24;
  localparam int PHASE_W       = 33;
  localparam int PHASE_SHIFT   = 31 - ANGLE_WIDTH;
  localparam int VEC_W         = 33;
  localparam int VEC_FRAC      = 30;
  localparam int TRIG_FRAC     = 15;
  localparam int TRIG_W        = TRIG_FRAC + 2;
  localparam int TRIG_SHIFT    = VEC_FRAC - TRIG_FRAC;
  localparam int PAIR_W        = 2 * TRIG_FRAC + 2;
  localparam int TRI_W         = 3 * TRIG_FRAC + 3;
  localparam int SUM_W         = TRI_W + 1;
  localparam int OUT_SHIFT     = 3 * TRIG_FRAC - (OUT_WIDTH - 1);

  localparam int CORDIC_STAGES = CORDIC_ITERS + 1;
  localparam int MULT_STAGES   = 3;
  localparam int PIPE_STAGES   = CORDIC_STAGES + MULT_STAGES;

  localparam logic signed [VEC_W-1:0] CORDIC_GAIN = VEC_W'(652032874);
  localparam logic signed [VEC_W-1:0] TRIG_RND    = VEC_W'(1) <<< (TRIG_SHIFT - 1);
  localparam logic signed [SUM_W-1:0] OUT_RND     = SUM_W'(1) <<< (OUT_SHIFT - 1);
  localparam logic signed [SUM_W-1:0] OUT_MAX     = (SUM_W'(1) <<< (OUT_WIDTH - 1)) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] OUT_MIN     = -(SUM_W'(1) <<< (OUT_WIDTH - 1));

  typedef struct packed {
    logic signed [TRIG_W-1:0] cos_h;
    logic signed [TRIG_W-1:0] sin_h;
  } trig_t;

  typedef struct packed {
    logic signed [OUT_WIDTH-1:0] w;
    logic signed [OUT_WIDTH-1:0] x;
    logic signed [OUT_WIDTH-1:0] y;
    logic signed [OUT_WIDTH-1:0] z;
  } quat_t;

  // atan(2^-idx), 2^32 phase units per turn
  function automatic logic signed [PHASE_W-1:0] atan_step(input int unsigned idx);
    case (idx)
      0:       return PHASE_W'(32'h20000000);
      1:       return PHASE_W'(32'h12E4051E);
      2:       return PHASE_W'(32'h09FB385B);
      3:       return PHASE_W'(32'h051111D4);
      4:       return PHASE_W'(32'h028B0D43);
      5:       return PHASE_W'(32'h0145D7E1);
      6:       return PHASE_W'(32'h00A2F61E);
      7:       return PHASE_W'(32'h00517C55);
      8:       return PHASE_W'(32'h0028BE53);
      9:       return PHASE_W'(32'h00145F2F);
      10:      return PHASE_W'(32'h000A2F98);
      11:      return PHASE_W'(32'h000517CC);
      12:      return PHASE_W'(32'h00028BE6);
      13:      return PHASE_W'(32'h000145F3);
      14:      return PHASE_W'(32'h0000A2FA);
      15:      return PHASE_W'(32'h0000517D);
      16:      return PHASE_W'(32'h000028BE);
      17:      return PHASE_W'(32'h0000145F);
      18:      return PHASE_W'(32'h00000A30);
      19:      return PHASE_W'(32'h00000518);
      20:      return PHASE_W'(32'h0000028C);
      21:      return PHASE_W'(32'h00000146);
      22:      return PHASE_W'(32'h000000A3);
      23:      return PHASE_W'(32'h00000051);
      default: return '0;
    endcase
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/e2q_cordic.sv
`default_nettype none

// rotation-mode CORDIC, one iteration per register stage, then rounding stage
module e2q_cordic (
  input  logic                               clk,
  input  logic                               en,
  input  logic [e2q_pkg::ANGLE_WIDTH-1:0]    angle,
  output e2q_pkg::trig_t                     trig
);

  logic signed [e2q_pkg::PHASE_W-1:0] phase_init;
  logic signed [e2q_pkg::PHASE_W-1:0] z_q [e2q_pkg::CORDIC_ITERS];
  logic signed [e2q_pkg::VEC_W-1:0]   x_q [e2q_pkg::CORDIC_ITERS];
  logic signed [e2q_pkg::VEC_W-1:0]   y_q [e2q_pkg::CORDIC_ITERS];
  logic signed [e2q_pkg::VEC_W-1:0]   x_rnd;
  logic signed [e2q_pkg::VEC_W-1:0]   y_rnd;
  logic signed [e2q_pkg::VEC_W-1:0]   x_sh;
  logic signed [e2q_pkg::VEC_W-1:0]   y_sh;

  // half angle: 2^(ANGLE_WIDTH-1) is pi, phase 2^32 is 2*pi
  assign phase_init = e2q_pkg::PHASE_W'($signed(angle)) <<< e2q_pkg::PHASE_SHIFT;

  for (genvar i = 0; i < e2q_pkg::CORDIC_ITERS; i++) begin : g_iter
    logic signed [e2q_pkg::PHASE_W-1:0] z_prev;
    logic signed [e2q_pkg::VEC_W-1:0]   x_prev;
    logic signed [e2q_pkg::VEC_W-1:0]   y_prev;

    if (i == 0) begin : g_first
      assign z_prev = phase_init;
      assign x_prev = e2q_pkg::CORDIC_GAIN;
      assign y_prev = '0;
    end else begin : g_next
      assign z_prev = z_q[i-1];
      assign x_prev = x_q[i-1];
      assign y_prev = y_q[i-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (!z_prev[e2q_pkg::PHASE_W-1]) begin
          x_q[i] <= x_prev - (y_prev >>> i);
          y_q[i] <= y_prev + (x_prev >>> i);
          z_q[i] <= z_prev - e2q_pkg::atan_step(i);
        end else begin
          x_q[i] <= x_prev + (y_prev >>> i);
          y_q[i] <= y_prev - (x_prev >>> i);
          z_q[i] <= z_prev + e2q_pkg::atan_step(i);
        end
      end
    end
  end

  assign x_rnd = x_q[e2q_pkg::CORDIC_ITERS-1] + e2q_pkg::TRIG_RND;
  assign y_rnd = y_q[e2q_pkg::CORDIC_ITERS-1] + e2q_pkg::TRIG_RND;
  assign x_sh  = x_rnd >>> e2q_pkg::TRIG_SHIFT;
  assign y_sh  = y_rnd >>> e2q_pkg::TRIG_SHIFT;

  always_ff @(posedge clk) begin
    if (en) begin
      trig.cos_h <= x_sh[e2q_pkg::TRIG_W-1:0];
      trig.sin_h <= y_sh[e2q_pkg::TRIG_W-1:0];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/e2q_combine.sv
`default_nettype none

// quaternion products: pair products, triple products, sums; round/saturate out
module e2q_combine (
  input  logic           clk,
  input  logic           en,
  input  e2q_pkg::trig_t pitch_trig,
  input  e2q_pkg::trig_t roll_trig,
  input  e2q_pkg::trig_t yaw_trig,
  output e2q_pkg::quat_t quat
);

  logic signed [e2q_pkg::PAIR_W-1:0] cc_q, ss_q, cs_q, sc_q;
  e2q_pkg::trig_t                    p_q;
  logic signed [e2q_pkg::TRI_W-1:0]  cc_cp_q, ss_sp_q, cs_cp_q, sc_sp_q;
  logic signed [e2q_pkg::TRI_W-1:0]  cc_sp_q, ss_cp_q, sc_cp_q, cs_sp_q;
  logic signed [e2q_pkg::SUM_W-1:0]  w_q, x_q, y_q, z_q;

  function automatic logic signed [e2q_pkg::OUT_WIDTH-1:0] finish(
    input logic signed [e2q_pkg::SUM_W-1:0] s
  );
    logic signed [e2q_pkg::SUM_W-1:0] r;
    r = (s + e2q_pkg::OUT_RND) >>> e2q_pkg::OUT_SHIFT;
    if (r > e2q_pkg::OUT_MAX) begin
      r = e2q_pkg::OUT_MAX;
    end else if (r < e2q_pkg::OUT_MIN) begin
      r = e2q_pkg::OUT_MIN;
    end
    return e2q_pkg::OUT_WIDTH'(r);
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      cc_q <= e2q_pkg::PAIR_W'(yaw_trig.cos_h) * e2q_pkg::PAIR_W'(roll_trig.cos_h);
      ss_q <= e2q_pkg::PAIR_W'(yaw_trig.sin_h) * e2q_pkg::PAIR_W'(roll_trig.sin_h);
      cs_q <= e2q_pkg::PAIR_W'(yaw_trig.cos_h) * e2q_pkg::PAIR_W'(roll_trig.sin_h);
      sc_q <= e2q_pkg::PAIR_W'(yaw_trig.sin_h) * e2q_pkg::PAIR_W'(roll_trig.cos_h);
      p_q  <= pitch_trig;

      cc_cp_q <= e2q_pkg::TRI_W'(cc_q) * e2q_pkg::TRI_W'(p_q.cos_h);
      ss_sp_q <= e2q_pkg::TRI_W'(ss_q) * e2q_pkg::TRI_W'(p_q.sin_h);
      cs_cp_q <= e2q_pkg::TRI_W'(cs_q) * e2q_pkg::TRI_W'(p_q.cos_h);
      sc_sp_q <= e2q_pkg::TRI_W'(sc_q) * e2q_pkg::TRI_W'(p_q.sin_h);
      cc_sp_q <= e2q_pkg::TRI_W'(cc_q) * e2q_pkg::TRI_W'(p_q.sin_h);
      ss_cp_q <= e2q_pkg::TRI_W'(ss_q) * e2q_pkg::TRI_W'(p_q.cos_h);
      sc_cp_q <= e2q_pkg::TRI_W'(sc_q) * e2q_pkg::TRI_W'(p_q.cos_h);
      cs_sp_q <= e2q_pkg::TRI_W'(cs_q) * e2q_pkg::TRI_W'(p_q.sin_h);

      w_q <= e2q_pkg::SUM_W'(cc_cp_q) + e2q_pkg::SUM_W'(ss_sp_q);
      x_q <= e2q_pkg::SUM_W'(cs_cp_q) - e2q_pkg::SUM_W'(sc_sp_q);
      y_q <= e2q_pkg::SUM_W'(cc_sp_q) + e2q_pkg::SUM_W'(ss_cp_q);
      z_q <= e2q_pkg::SUM_W'(sc_cp_q) - e2q_pkg::SUM_W'(cs_sp_q);
    end
  end

  assign quat.w = finish(w_q);
  assign quat.x = finish(x_q);
  assign quat.y = finish(y_q);
  assign quat.z = finish(z_q);

endmodule

`default_nettype wire

FILE: rtl/core/euler_to_quaternion_unit.sv
`default_nettype none

// Z-Y-X Euler angles (binary angles, full scale = +/-pi) to a Q1.15 unit
// quaternion. Fully pipelined, one transaction per cycle while in_stall is
// low, through 24 CORDIC iteration stages and one rounding stage per angle,
// three multiply/add stages, one output register. A two-entry output buffer
// lets the pipeline take a new transaction in the cycle the output first
// stalls; in_stall is registered and rises only when that buffer is full.
module euler_to_quaternion_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [e2q_pkg::ANGLE_WIDTH-1:0] pitch_angle,
  input  logic signed [e2q_pkg::ANGLE_WIDTH-1:0] roll_angle,
  input  logic signed [e2q_pkg::ANGLE_WIDTH-1:0] yaw_angle,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [e2q_pkg::OUT_WIDTH-1:0]   quat_w,
  output logic signed [e2q_pkg::OUT_WIDTH-1:0]   quat_x,
  output logic signed [e2q_pkg::OUT_WIDTH-1:0]   quat_y,
  output logic signed [e2q_pkg::OUT_WIDTH-1:0]   quat_z
);

  logic                               adv;
  logic                               take;
  logic [e2q_pkg::PIPE_STAGES-1:0]    vld;
  logic                               skid_valid;
  e2q_pkg::trig_t                     pitch_trig, roll_trig, yaw_trig;
  e2q_pkg::quat_t                     quat_new;
  e2q_pkg::quat_t                     out_q;
  e2q_pkg::quat_t                     skid_q;

  assign adv      = !skid_valid;
  assign take     = out_valid && !out_stall;
  assign in_stall = skid_valid;

  e2q_cordic u_pitch (
    .clk   (clk),
    .en    (adv),
    .angle (pitch_angle),
    .trig  (pitch_trig)
  );

  e2q_cordic u_roll (
    .clk   (clk),
    .en    (adv),
    .angle (roll_angle),
    .trig  (roll_trig)
  );

  e2q_cordic u_yaw (
    .clk   (clk),
    .en    (adv),
    .angle (yaw_angle),
    .trig  (yaw_trig)
  );

  e2q_combine u_combine (
    .clk        (clk),
    .en         (adv),
    .pitch_trig (pitch_trig),
    .roll_trig  (roll_trig),
    .yaw_trig   (yaw_trig),
    .quat       (quat_new)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[e2q_pkg::PIPE_STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (adv && vld[e2q_pkg::PIPE_STAGES-1]) begin
      if (!out_valid || take) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && vld[e2q_pkg::PIPE_STAGES-1]) begin
      if (!out_valid || take) begin
        out_q <= quat_new;
      end else begin
        skid_q <= quat_new;
      end
    end else if (take && skid_valid) begin
      out_q <= skid_q;
    end
  end

  assign quat_w = out_q.w;
  assign quat_x = out_q.x;
  assign quat_y = out_q.y;
  assign quat_z = out_q.z;

endmodule

`default_nettype wire

FILE: tb/euler_to_quaternion_unit_tb.sv
module euler_to_quaternion_unit_tb;

  localparam int AW            = e2q_pkg::ANGLE_WIDTH;
  localparam int OW            = e2q_pkg::OUT_WIDTH;
  localparam int TRIG_Q        = 15;
  localparam int PROD_SHIFT    = 3 * TRIG_Q - (OW - 1);
  localparam int ROT_STEPS     = 24;
  localparam longint ROT_GAIN  = 652032874;
  localparam int NUM_RANDOM    = 1500;
  localparam int IDLE_LIMIT    = 4000;
  localparam int SETTLE_CYCLES = 40;
  localparam int PRINT_LIMIT   = 40;

  typedef struct packed {
    logic signed [OW-1:0] w;
    logic signed [OW-1:0] x;
    logic signed [OW-1:0] y;
    logic signed [OW-1:0] z;
  } quat_t;

  logic                 clk         = 1'b0;
  logic                 rst         = 1'b1;
  logic                 in_valid    = 1'b0;
  logic signed [AW-1:0] pitch_angle = '0;
  logic signed [AW-1:0] roll_angle  = '0;
  logic signed [AW-1:0] yaw_angle   = '0;
  logic                 out_stall   = 1'b0;
  logic                 in_stall;
  logic                 out_valid;
  logic signed [OW-1:0] quat_w;
  logic signed [OW-1:0] quat_x;
  logic signed [OW-1:0] quat_y;
  logic signed [OW-1:0] quat_z;

  quat_t pending_quats[$];
  int    mismatches      = 0;
  int    items_sent      = 0;
  int    results_checked = 0;
  int    idle_cycles     = 0;
  int    stall_pct       = 0;
  int    stall_span      = 0;

  euler_to_quaternion_unit u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .pitch_angle (pitch_angle),
    .roll_angle  (roll_angle),
    .yaw_angle   (yaw_angle),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .quat_w      (quat_w),
    .quat_x      (quat_x),
    .quat_y      (quat_y),
    .quat_z      (quat_z)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // cos and sin of half the angle, rotation CORDIC, rounded to Q2.15
  function automatic void half_angle_trig(input logic signed [AW-1:0] angle,
                                          output longint c, output longint s);
    longint rot_step [ROT_STEPS];
    longint phase, vx, vy, dx, dy;
    rot_step = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
                 32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
                 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
                 32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
                 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
                 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};
    phase = longint'(angle) * (longint'(1) << (31 - AW));
    vx = ROT_GAIN;
    vy = 0;
    for (int i = 0; i < ROT_STEPS; i++) begin
      dx = vy >>> i;
      dy = vx >>> i;
      if (phase >= 0) begin
        vx -= dx;
        vy += dy;
        phase -= rot_step[i];
      end else begin
        vx += dx;
        vy -= dy;
        phase += rot_step[i];
      end
    end
    c = (vx + (longint'(1) << (30 - TRIG_Q - 1))) >>> (30 - TRIG_Q);
    s = (vy + (longint'(1) << (30 - TRIG_Q - 1))) >>> (30 - TRIG_Q);
  endfunction

  function automatic logic signed [OW-1:0] round_sat(input longint acc);
    longint r, hi, lo;
    hi = (longint'(1) << (OW - 1)) - 1;
    lo = -(longint'(1) << (OW - 1));
    r = (acc + (longint'(1) << (PROD_SHIFT - 1))) >>> PROD_SHIFT;
    if (r > hi) r = hi;
    if (r < lo) r = lo;
    return OW'(r);
  endfunction

  function automatic quat_t predict_quat(input logic signed [AW-1:0] p, r, y);
    longint cp, sp, cr, sr, cy, sy;
    quat_t q;
    half_angle_trig(p, cp, sp);
    half_angle_trig(r, cr, sr);
    half_angle_trig(y, cy, sy);
    q.w = round_sat(cy * cr * cp + sy * sr * sp);
    q.x = round_sat(cy * sr * cp - sy * cr * sp);
    q.y = round_sat(cy * cr * sp + sy * sr * cp);
    q.z = round_sat(sy * cr * cp - cy * sr * sp);
    return q;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) $display("ERROR: %s", msg);
  endtask

  task automatic check_field(input string name, input logic signed [OW-1:0] got, want);
    if (got !== want)
      report_mismatch($sformatf("result %0d quat_%s: got %0d, expected %0d",
                                results_checked, name, got, want));
  endtask

  // output check first, then record new input transaction; also the watchdog
  always @(posedge clk) begin
    quat_t exp_q;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending_quats.size() == 0) begin
          report_mismatch($sformatf("unexpected result w=%0d x=%0d y=%0d z=%0d",
                                    quat_w, quat_x, quat_y, quat_z));
        end else begin
          exp_q = pending_quats.pop_front();
          check_field("w", quat_w, exp_q.w);
          check_field("x", quat_x, exp_q.x);
          check_field("y", quat_y, exp_q.y);
          check_field("z", quat_z, exp_q.z);
          results_checked++;
        end
      end
      if (in_valid && !in_stall) begin
        pending_quats.insert(pending_quats.size(),
                             predict_quat(pitch_angle, roll_angle, yaw_angle));
        items_sent++;
      end
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("watchdog: no transaction for %0d cycles", idle_cycles);
          $display("Mismatches found");
          $finish;
        end
      end
    end
  end

  // receiver back-pressure: the stall rate is redrawn each time stall_span runs out
  always @(negedge clk) begin
    if (stall_span == 0) begin
      stall_span = $urandom_range(300, 50);
      case ($urandom_range(3))
        0: stall_pct = 0;
        1: stall_pct = 25;
        2: stall_pct = 60;
        default: stall_pct = 90;
      endcase
    end
    stall_span--;
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic send_angles(input int p, input int r, input int y);
    pitch_angle <= AW'(p);
    roll_angle  <= AW'(r);
    yaw_angle   <= AW'(y);
    in_valid    <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic pause_sender(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (pending_quats.size() != 0) @(negedge clk);
  endtask

  function automatic int random_angle();
    int pick;
    pick = $urandom_range(99);
    if (pick < 60) return int'($urandom);
    if (pick < 75) return int'($urandom_range(128)) - 64;
    if (pick < 90) return int'($urandom_range(7)) * 8192 + int'($urandom_range(32)) - 16;
    case ($urandom_range(5))
      0: return -32768;
      1: return 32767;
      2: return 16384;
      3: return -16384;
      4: return 0;
      default: return -1;
    endcase
  endfunction

  task automatic test_extreme_angles();
    send_angles(0, 0, 0);
    send_angles(-32768, -32768, -32768);
    send_angles(32767, 32767, 32767);
    send_angles(-32768, 0, 0);
    send_angles(0, -32768, 0);
    send_angles(0, 0, -32768);
    send_angles(32767, 0, 0);
    send_angles(0, 32767, 0);
    send_angles(0, 0, 32767);
    send_angles(16384, 0, 0);
    send_angles(0, -16384, 0);
    send_angles(0, 0, 16384);
    send_angles(1, -1, 1);
    send_angles(-1, 1, -1);
    send_angles(8192, 8192, 8192);
    send_angles(-8192, 16384, -24576);
    send_angles(32767, -32768, 32767);
    send_angles(-32768, 32767, -32768);
    send_angles(12345, -23456, 30000);
    wait_for_drain();
  endtask

  // full pipeline drains, then restarts from empty
  task automatic test_drain_and_restart();
    repeat (30) send_angles(random_angle(), random_angle(), random_angle());
    wait_for_drain();
    repeat (30) send_angles(random_angle(), random_angle(), random_angle());
  endtask

  task automatic test_random_angles();
    int burst_left;
    burst_left = 0;
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (burst_left == 0) begin
        burst_left = ($urandom_range(9) == 0) ? $urandom_range(200, 60)
                                              : $urandom_range(30, 1);
        pause_sender(($urandom_range(3) == 0) ? 0 : $urandom_range(12, 1));
      end
      burst_left--;
      send_angles(random_angle(), random_angle(), random_angle());
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_extreme_angles();
    test_drain_and_restart();
    test_random_angles();
    while (pending_quats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d angle triples (extremes, axis multiples, small and full-range angles)",
             items_sent);
    $display("with bursty input and varying output back-pressure; %0d quaternions compared",
             results_checked);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
